// ===== design/phse_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the pointer hash set engine.
// No dependencies.

package phse_pkg;

  localparam int KEY_W     = 48;
  localparam int HANDLE_W  = 48;
  localparam int STATUS_W  = 3;
  localparam int REQ_W     = 2;
  // BUCKETS must be a power of two: the bucket is a bit field of the key.
  localparam int BUCKETS   = 256;
  localparam int WAYS      = 4;
  localparam int HASHSHIFT = 5;
  localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_PRESENT   = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd5;

  // One bucket: all ways side by side in one memory row.
  typedef struct packed {
    logic [WAYS-1:0]                valid;
    logic [WAYS-1:0][KEY_W-1:0]     keys;
    logic [WAYS-1:0][HANDLE_W-1:0]  handles;
  } row_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             has_free;
    logic [WAY_W-1:0] free_way;
  } match_t;

endpackage

// ===== design/phse_match.sv =====
`timescale 1ns / 1ps
// Compares a key against all ways of one bucket row and finds the lowest free way.
// Depends on phse_pkg.

module phse_match (
  input  phse_pkg::row_t                   row,
  input  logic [phse_pkg::KEY_W-1:0]       key,
  output phse_pkg::match_t                 match
);

  always_comb begin
    match = '0;
    for (int w = phse_pkg::WAYS - 1; w >= 0; w--) begin
      if (row.valid[w] && (row.keys[w] == key)) begin
        match.hit     = 1'b1;
        match.hit_way = w[phse_pkg::WAY_W-1:0];
      end
      if (!row.valid[w]) begin
        match.has_free = 1'b1;
        match.free_way = w[phse_pkg::WAY_W-1:0];
      end
    end
  end

endmodule

// ===== design/pointer_hash_set_engine.sv =====
`timescale 1ns / 1ps
// Top level of the pointer hash set engine: bucket memory, control and result registers.
// Depends on phse_pkg and phse_match.
//
// Usage:
//   Request channel: drive req_type, key and handle with start high; the item is
//   taken at the rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with status and
//   found_handle; the receiver must take it then, it cannot stall.
//   Timing: the bucket read registers at the accepting edge; compare, write-back
//   and the result register take the next cycle, at whose end done rises.
//   A new request is not taken until the last is done: busy is high in the
//   cycle after an accept, for the bucket memory read-modify-write. Requests do
//   not overlap, so no forwarding between them is needed.
//   Reset: rst (synchronous) starts a clearing pass that writes every bucket row
//   empty, one row per cycle, with busy held high.
//   Request type 3 answers not found and leaves the table alone.

module pointer_hash_set_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [phse_pkg::REQ_W-1:0]          req_type,
  input  logic [phse_pkg::KEY_W-1:0]          key,
  input  logic [phse_pkg::HANDLE_W-1:0]       handle,
  output logic                                done,
  output logic [phse_pkg::STATUS_W-1:0]       status,
  output logic [phse_pkg::HANDLE_W-1:0]       found_handle
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  state_t state;

  phse_pkg::row_t mem [phse_pkg::BUCKETS];
  phse_pkg::row_t rd_row;
  phse_pkg::row_t new_row;
  phse_pkg::row_t wr_row;
  phse_pkg::match_t match;

  logic                              accept;
  logic [phse_pkg::BKT_W-1:0]        in_bucket;
  logic [phse_pkg::BKT_W-1:0]        clr_idx;
  logic [phse_pkg::BKT_W-1:0]        wr_addr;
  logic                              mem_we;

  logic [phse_pkg::REQ_W-1:0]        req_q;
  logic [phse_pkg::KEY_W-1:0]        key_q;
  logic [phse_pkg::HANDLE_W-1:0]     handle_q;
  logic [phse_pkg::BKT_W-1:0]        bucket_q;

  logic [phse_pkg::STATUS_W-1:0]     status_next;
  logic [phse_pkg::HANDLE_W-1:0]     found_next;

  assign accept    = start && !busy;
  assign in_bucket = (phse_pkg::BUCKETS > 1) ?
                     key[phse_pkg::HASHSHIFT +: phse_pkg::BKT_W] : '0;

  phse_match u_match (
    .row   (rd_row),
    .key   (key_q),
    .match (match)
  );

  always_comb begin
    new_row     = rd_row;
    status_next = phse_pkg::STATUS_NOT_FOUND;
    found_next  = '0;
    case (req_q)
      phse_pkg::REQ_INSERT: begin
        if (match.hit) begin
          status_next = phse_pkg::STATUS_PRESENT;
        end else if (match.has_free) begin
          new_row.valid[match.free_way]   = 1'b1;
          new_row.keys[match.free_way]    = key_q;
          new_row.handles[match.free_way] = handle_q;
          status_next = phse_pkg::STATUS_ADDED;
        end else begin
          status_next = phse_pkg::STATUS_FULL;
        end
      end
      phse_pkg::REQ_LOOKUP: begin
        if (match.hit && (key_q != '0)) begin
          status_next = phse_pkg::STATUS_FOUND;
          found_next  = rd_row.handles[match.hit_way];
        end
      end
      phse_pkg::REQ_REMOVE: begin
        if (match.hit) begin
          new_row.valid[match.hit_way] = 1'b0;
          status_next = phse_pkg::STATUS_REMOVED;
        end
      end
      default: begin
        status_next = phse_pkg::STATUS_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = bucket_q;
    wr_row  = new_row;
    if (state == S_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = clr_idx;
      wr_row  = '0;
    end else if (state == S_LOOK) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_row;
    end
    if (accept) begin
      rd_row <= mem[in_bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q    <= req_type;
      key_q    <= key;
      handle_q <= handle;
      bucket_q <= in_bucket;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      busy         <= 1'b1;
      done         <= 1'b0;
      clr_idx      <= '0;
      status       <= '0;
      found_handle <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == phse_pkg::BKT_W'(phse_pkg::BUCKETS - 1)) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOK;
            busy  <= 1'b1;
          end
        end
        S_LOOK: begin
          state        <= S_IDLE;
          busy         <= 1'b0;
          done         <= 1'b1;
          status       <= status_next;
          found_handle <= found_next;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule
